[hw/rtl/sst_pkg.sv]
// ============================================================================
// sst_pkg
// Shared sizes, command codes and result type of the static slot table.
// ============================================================================
`default_nettype none

package sst_pkg;

    localparam int CAPACITY   = 16;
    localparam int KEY_WIDTH  = 16;
    localparam int DATA_WIDTH = 48;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int SCAN_W = IDX_W + 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMD_W  = 2;
    localparam int SLOT_W = KEY_WIDTH + DATA_WIDTH;

    localparam int IN_TDATA_W  = ((KEY_WIDTH + DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_RAW_W   = KEY_WIDTH + DATA_WIDTH + CNT_W + 2;
    localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_STATUS = 2'd3
    } t_cmd;

    typedef struct packed {
        logic                  status;
        logic [KEY_WIDTH-1:0]  key;
        logic [DATA_WIDTH-1:0] payload;
        logic [CNT_W-1:0]      count;
        logic                  empty;
        logic                  full;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/sst_ram.sv]
// ============================================================================
// sst_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
`default_nettype none

module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

[hw/rtl/sst_ctrl.sv]
// ============================================================================
// sst_ctrl
// Slot sequencer: keeps valid bits and the count, scans slots one per cycle
// through the shared key comparator and drives the slot RAM.
// ============================================================================
`default_nettype none

module sst_ctrl (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cmd_vld,
    output logic                                 o_cmd_rdy,
    input  wire sst_pkg::t_cmd                   i_cmd,
    input  wire logic [sst_pkg::KEY_WIDTH-1:0]   i_key,
    input  wire logic [sst_pkg::DATA_WIDTH-1:0]  i_payload,
    output logic                                 o_res_vld,
    input  wire logic                            i_res_rdy,
    output sst_pkg::t_result                     o_res,
    output logic                                 o_ram_wr_en,
    output logic [sst_pkg::IDX_W-1:0]            o_ram_wr_addr,
    output logic [sst_pkg::SLOT_W-1:0]           o_ram_wr_data,
    output logic [sst_pkg::IDX_W-1:0]            o_ram_rd_addr,
    input  wire logic [sst_pkg::SLOT_W-1:0]      i_ram_rd_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                          r_state;
    sst_pkg::t_cmd                   r_cmd;
    logic [sst_pkg::KEY_WIDTH-1:0]   r_key;
    logic [sst_pkg::DATA_WIDTH-1:0]  r_payload;
    logic [sst_pkg::CAPACITY-1:0]    r_valid;
    logic [sst_pkg::CNT_W-1:0]       r_count;
    logic [sst_pkg::SCAN_W-1:0]      r_idx;
    logic                            r_chk;
    logic [sst_pkg::IDX_W-1:0]       r_chk_idx;
    logic                            r_status;
    logic [sst_pkg::KEY_WIDTH-1:0]   r_key_out;
    logic [sst_pkg::DATA_WIDTH-1:0]  r_payload_out;

    logic [sst_pkg::IDX_W-1:0]       idx;
    logic [sst_pkg::KEY_WIDTH-1:0]   rd_key;
    logic [sst_pkg::DATA_WIDTH-1:0]  rd_payload;
    logic                            hit;
    logic                            free;

    assign idx        = r_idx[sst_pkg::IDX_W-1:0];
    assign rd_key     = i_ram_rd_data[sst_pkg::KEY_WIDTH-1:0];
    assign rd_payload = i_ram_rd_data[sst_pkg::SLOT_W-1:sst_pkg::KEY_WIDTH];
    assign hit        = r_chk && r_valid[r_chk_idx] && (rd_key == r_key);
    assign free       = !r_valid[idx];

    assign o_cmd_rdy     = (r_state == S_IDLE);
    assign o_res_vld     = (r_state == S_DONE);
    assign o_ram_wr_en   = (r_state == S_INS) && free;
    assign o_ram_wr_addr = idx;
    assign o_ram_wr_data = {r_payload, r_key};
    assign o_ram_rd_addr = idx;

    always_comb begin
        o_res.status  = r_status;
        o_res.key     = r_key_out;
        o_res.payload = r_payload_out;
        o_res.count   = r_count;
        o_res.empty   = (r_count == '0);
        o_res.full    = (r_count == sst_pkg::CNT_W'(sst_pkg::CAPACITY));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_count <= '0;
            r_chk   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_vld) begin
                        r_cmd         <= i_cmd;
                        r_key         <= i_key;
                        r_payload     <= i_payload;
                        r_idx         <= '0;
                        r_chk         <= 1'b0;
                        r_status      <= 1'b0;
                        r_key_out     <= '0;
                        r_payload_out <= '0;
                        unique case (i_cmd)
                            sst_pkg::CMD_INSERT: r_state <= S_INS;
                            sst_pkg::CMD_REMOVE,
                            sst_pkg::CMD_SEARCH: r_state <= S_SCAN;
                            default:             r_state <= S_DONE;
                        endcase
                    end
                end
                S_INS: begin
                    priority if (free) begin
                        r_valid[idx] <= 1'b1;
                        r_count      <= r_count + 1'b1;
                        r_state      <= S_DONE;
                    end else if (idx == sst_pkg::IDX_W'(sst_pkg::CAPACITY - 1)) begin
                        r_status <= 1'b1;
                        r_state  <= S_DONE;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SCAN: begin
                    priority if (hit) begin
                        r_key_out     <= rd_key;
                        r_payload_out <= rd_payload;
                        if (r_cmd == sst_pkg::CMD_REMOVE) begin
                            r_valid[r_chk_idx] <= 1'b0;
                            r_count            <= r_count - 1'b1;
                        end
                        r_state <= S_DONE;
                    end else if (r_idx == sst_pkg::SCAN_W'(sst_pkg::CAPACITY)) begin
                        r_status <= 1'b1;
                        r_state  <= S_DONE;
                    end else begin
                        r_chk     <= 1'b1;
                        r_chk_idx <= idx;
                        r_idx     <= r_idx + 1'b1;
                    end
                end
                S_DONE: begin
                    if (i_res_rdy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[hw/rtl/static_slot_table.sv]
// ============================================================================
// static_slot_table
// Fixed table of keyed records with insert, remove, search and status query.
// ============================================================================
// One command beat enters on the s_axis channel: tuser carries the command,
// tdata the key and the payload. One result beat leaves on m_axis for each
// command: tuser carries the status (0 done or found, 1 full or not found),
// tdata the key and payload found (zero otherwise), the item count and the
// empty and full flags.
// Insert walks the valid bits one slot per cycle and writes the lowest empty
// slot. Remove and search read the slot RAM one slot per cycle through its
// registered read port and one key comparator. A status query skips the slot
// walk. The result sits in an output register; the next command is accepted
// while it waits there.
// s_axis_tready is low while a command is in progress, and while a finished
// result waits behind a stalled m_axis receiver with the output register full.
// Reset marks every slot empty at once; no clearing pass is needed.
// ============================================================================
`default_nettype none

module static_slot_table (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [15:0] key, [63:16] payload
    input  wire logic [sst_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] command
    input  wire logic [sst_pkg::CMD_W-1:0]        s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [15:0] key_out, [63:16] payload_out, [68:64] item_count, [69] is_empty,
    // [70] is_full, [71] zero
    output logic [sst_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    // [0] status
    output logic [0:0]                            m_axis_tuser
);

    logic                             res_vld;
    logic                             res_rdy;
    sst_pkg::t_result                 res;
    logic                             ram_wr_en;
    logic [sst_pkg::IDX_W-1:0]        ram_wr_addr;
    logic [sst_pkg::SLOT_W-1:0]       ram_wr_data;
    logic [sst_pkg::IDX_W-1:0]        ram_rd_addr;
    logic [sst_pkg::SLOT_W-1:0]       ram_rd_data;

    logic                             r_out_vld;
    sst_pkg::t_result                 r_out;

    sst_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_vld     (s_axis_tvalid),
        .o_cmd_rdy     (s_axis_tready),
        .i_cmd         (sst_pkg::t_cmd'(s_axis_tuser)),
        .i_key         (s_axis_tdata[sst_pkg::KEY_WIDTH-1:0]),
        .i_payload     (s_axis_tdata[sst_pkg::SLOT_W-1:sst_pkg::KEY_WIDTH]),
        .o_res_vld     (res_vld),
        .i_res_rdy     (res_rdy),
        .o_res         (res),
        .o_ram_wr_en   (ram_wr_en),
        .o_ram_wr_addr (ram_wr_addr),
        .o_ram_wr_data (ram_wr_data),
        .o_ram_rd_addr (ram_rd_addr),
        .i_ram_rd_data (ram_rd_data)
    );

    sst_ram #(
        .WIDTH (sst_pkg::SLOT_W),
        .DEPTH (sst_pkg::CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // take a finished result when the output register is free or draining
    assign res_rdy = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_rdy) begin
            r_out_vld <= res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_rdy && res_vld) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tdata  = sst_pkg::OUT_TDATA_W'({r_out.full, r_out.empty, r_out.count,
                                                  r_out.payload, r_out.key});

endmodule

`default_nettype wire

[dv/sst_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// sst_checker
// Watches both stream channels of the static slot table, predicts each result
// beat from its own copy of the slots and compares the beats field by field.
// ============================================================================
module sst_checker
    import sst_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cmd_tvalid,
    input  wire logic                   i_cmd_tready,
    // [15:0] key, [63:16] payload
    input  wire logic [IN_TDATA_W-1:0]  i_cmd_tdata,
    // [1:0] command
    input  wire logic [CMD_W-1:0]       i_cmd_tuser,
    input  wire logic                   i_rsp_tvalid,
    input  wire logic                   i_rsp_tready,
    // [15:0] key_out, [63:16] payload_out, [68:64] item_count, [69] is_empty,
    // [70] is_full, [71] zero
    input  wire logic [OUT_TDATA_W-1:0] i_rsp_tdata,
    // [0] status
    input  wire logic [0:0]             i_rsp_tuser,
    output int                          o_fail_count,
    output int                          o_pending
);

    logic                  tbl_used    [CAPACITY];
    logic [KEY_WIDTH-1:0]  tbl_key     [CAPACITY];
    logic [DATA_WIDTH-1:0] tbl_payload [CAPACITY];

    t_result result_q[$];
    int      mismatches = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = result_q.size();

    function automatic t_result apply_command(t_cmd cmd, logic [KEY_WIDTH-1:0] key,
                                              logic [DATA_WIDTH-1:0] payload);
        t_result r;
        int      hit;
        int      n;
        r   = '0;
        hit = -1;
        n   = 0;
        case (cmd)
            CMD_INSERT: begin
                r.status = 1'b1;
                for (int i = 0; i < CAPACITY; i++) begin
                    if (!tbl_used[i]) begin
                        tbl_used[i]    = 1'b1;
                        tbl_key[i]     = key;
                        tbl_payload[i] = payload;
                        r.status       = 1'b0;
                        break;
                    end
                end
            end
            CMD_REMOVE, CMD_SEARCH: begin
                for (int i = 0; i < CAPACITY; i++) begin
                    if (tbl_used[i] && tbl_key[i] == key) begin
                        hit = i;
                        break;
                    end
                end
                if (hit < 0) begin
                    r.status = 1'b1;
                end else begin
                    r.key     = tbl_key[hit];
                    r.payload = tbl_payload[hit];
                    if (cmd == CMD_REMOVE) tbl_used[hit] = 1'b0;
                end
            end
            default: ;
        endcase
        for (int i = 0; i < CAPACITY; i++) if (tbl_used[i]) n++;
        r.count = n[CNT_W-1:0];
        r.empty = (n == 0);
        r.full  = (n == CAPACITY);
        return r;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < CAPACITY; i++) tbl_used[i] = 1'b0;
            result_q.delete();
        end else begin
            if (i_rsp_tvalid && i_rsp_tready) begin
                if (result_q.size() == 0) begin
                    $error("result beat with no command pending");
                    mismatches++;
                end else begin
                    want = result_q.pop_front();
                    check_field("status", want.status, i_rsp_tuser[0]);
                    check_field("key_out", want.key, i_rsp_tdata[KEY_WIDTH-1:0]);
                    check_field("payload_out", want.payload,
                                i_rsp_tdata[KEY_WIDTH +: DATA_WIDTH]);
                    check_field("item_count", want.count,
                                i_rsp_tdata[KEY_WIDTH+DATA_WIDTH +: CNT_W]);
                    check_field("is_empty", want.empty,
                                i_rsp_tdata[KEY_WIDTH+DATA_WIDTH+CNT_W]);
                    check_field("is_full", want.full,
                                i_rsp_tdata[KEY_WIDTH+DATA_WIDTH+CNT_W+1]);
                end
            end
            if (i_cmd_tvalid && i_cmd_tready) begin
                result_q.push_back(apply_command(t_cmd'(i_cmd_tuser),
                                                 i_cmd_tdata[KEY_WIDTH-1:0],
                                                 i_cmd_tdata[KEY_WIDTH +: DATA_WIDTH]));
            end
        end
    end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Stimulus and verdict for the static slot table.
// ============================================================================
// A directed run covers the empty and full table, misses, duplicate keys and
// the extreme keys; then random phases lean toward filling, draining or
// mixed traffic over a small key set so that searches and removes hit often.
// Both channels idle at random; the checker predicts and compares every beat.
// ============================================================================
module tb_top;
    import sst_pkg::*;

    localparam int NUM_RANDOM = 1550;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [CMD_W-1:0]       s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;

    int fail_count;
    int pending;

    logic                 tx_free = 1'b0;
    logic                 rx_free = 1'b0;
    int                   rx_left = 0;
    logic [KEY_WIDTH-1:0] key_pool[8];

    static_slot_table uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    sst_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_tvalid (s_axis_tvalid),
        .i_cmd_tready (s_axis_tready),
        .i_cmd_tdata  (s_axis_tdata),
        .i_cmd_tuser  (s_axis_tuser),
        .i_rsp_tvalid (m_axis_tvalid),
        .i_rsp_tready (m_axis_tready),
        .i_rsp_tdata  (m_axis_tdata),
        .i_rsp_tuser  (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin : rx_drive
        int roll;
        roll = $urandom_range(0, 99);
        if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else if (rx_free) begin
            m_axis_tready <= 1'b1;
        end else if (roll < 55) begin
            m_axis_tready <= 1'b1;
            rx_left       <= $urandom_range(0, 6);
        end else if (roll < 90) begin
            m_axis_tready <= 1'b0;
            rx_left       <= $urandom_range(0, 3);
        end else begin
            m_axis_tready <= 1'b0;
            rx_left       <= $urandom_range(10, 40);
        end
    end

    function automatic logic [DATA_WIDTH-1:0] rand_payload();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [KEY_WIDTH-1:0] pick_key();
        if ($urandom_range(0, 99) < 70) return key_pool[$urandom_range(0, 7)];
        return KEY_WIDTH'($urandom);
    endfunction

    function automatic int next_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (tx_free || roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_beat(t_cmd cmd, logic [KEY_WIDTH-1:0] key,
                             logic [DATA_WIDTH-1:0] payload);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {payload, key};
        do @(posedge i_clk); while (!s_axis_tready);
        gap = next_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : stimulus
        int   sent;
        int   phase_len;
        int   mode;
        int   roll;
        t_cmd cmd;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(CMD_STATUS, 16'h0000, '0);
        send_beat(CMD_SEARCH, 16'h1234, '0);
        send_beat(CMD_REMOVE, 16'hFFFF, '1);
        send_beat(CMD_INSERT, 16'h0000, '0);
        send_beat(CMD_INSERT, 16'hFFFF, '1);
        send_beat(CMD_INSERT, 16'hFFFF, 48'h5A5A_A5A5_0F0F);
        send_beat(CMD_SEARCH, 16'hFFFF, rand_payload());
        send_beat(CMD_REMOVE, 16'hFFFF, rand_payload());
        send_beat(CMD_SEARCH, 16'hFFFF, rand_payload());
        for (int i = 0; i < CAPACITY - 2; i++) begin
            send_beat(CMD_INSERT, 16'h5555 ^ KEY_WIDTH'(i * 16'h1111), rand_payload());
        end
        send_beat(CMD_INSERT, 16'hAAAA, '1);
        send_beat(CMD_SEARCH, 16'h0000, rand_payload());
        send_beat(CMD_REMOVE, 16'h0000, rand_payload());
        send_beat(CMD_STATUS, 16'hFFFF, '1);
        s_axis_tvalid <= 1'b0;
        drain_results();

        sent = 0;
        while (sent < NUM_RANDOM) begin
            phase_len = $urandom_range(40, 160);
            mode      = $urandom_range(0, 2);
            tx_free   <= ($urandom_range(0, 3) == 0);
            rx_free   <= ($urandom_range(0, 3) == 0);
            for (int i = 0; i < 8; i++) key_pool[i] = KEY_WIDTH'($urandom);
            if ($urandom_range(0, 1) == 0) key_pool[0] = '0;
            if ($urandom_range(0, 1) == 0) key_pool[7] = '1;
            for (int n = 0; n < phase_len && sent < NUM_RANDOM; n++) begin
                roll = $urandom_range(0, 99);
                case (mode)
                    0:       cmd = roll < 60 ? CMD_INSERT : roll < 75 ? CMD_REMOVE :
                                   roll < 90 ? CMD_SEARCH : CMD_STATUS;
                    1:       cmd = roll < 20 ? CMD_INSERT : roll < 70 ? CMD_REMOVE :
                                   roll < 90 ? CMD_SEARCH : CMD_STATUS;
                    default: cmd = roll < 25 ? CMD_INSERT : roll < 55 ? CMD_REMOVE :
                                   roll < 90 ? CMD_SEARCH : CMD_STATUS;
                endcase
                send_beat(cmd, pick_key(), rand_payload());
                sent++;
            end
            if ($urandom_range(0, 2) == 0) begin
                s_axis_tvalid <= 1'b0;
                drain_results();
            end
        end

        s_axis_tvalid <= 1'b0;
        drain_results();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #(20_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
